// ===== rtl/core/jacobi_grid_relaxation_macros.svh =====
// ----------------------------------------------------------------------------
// Jacobi grid relaxation assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef JACOBI_GRID_RELAXATION_MACROS_SVH
`define JACOBI_GRID_RELAXATION_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define JGR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jacobi_grid_relaxation: port check failed");

// next-cycle implication
`define JGR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jacobi_grid_relaxation: port check failed");

`endif

// ===== rtl/core/jgr_pkg.sv =====
// ----------------------------------------------------------------------------
// jgr_pkg
// Types, codes and defaults shared by the Jacobi grid relaxation block.
// ----------------------------------------------------------------------------
`default_nettype none

package jgr_pkg;

	// default geometry and value width
	localparam int JGR_GRID_MAX   = 64;
	localparam int JGR_VALUE_BITS = 32;

	// request modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_GRID_SIZE  = 2'd0;
	localparam logic [1:0] CFG_PRECISION  = 2'd1;
	localparam logic [1:0] CFG_MAX_SWEEPS = 2'd2;

	// configuration reset values
	localparam logic [6:0]  RST_GRID_SIZE  = 7'd20;
	localparam logic [30:0] RST_PRECISION  = 31'd655;
	localparam logic [15:0] RST_MAX_SWEEPS = 16'd65535;

	typedef struct packed {
		logic [1:0]         mode;
		logic [5:0]         row;
		logic [5:0]         col;
		logic signed [31:0] cell_value;
	} jgr_req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [15:0]        sweep_count;
		logic               converged;
	} jgr_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/jgr_cell.sv =====
// ----------------------------------------------------------------------------
// jgr_cell
// One cell of the stencil window: holds a grid value, passes it on when shifted.
// ----------------------------------------------------------------------------
`default_nettype none

module jgr_cell #(
	parameter int W = 32
) (
	input  wire logic                clk,
	input  wire logic                shift,
	input  wire logic signed [W-1:0] d,
	output logic signed [W-1:0]      q
);

	logic signed [W-1:0] val_q;

	// value moves one place down the window on each shift
	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

`default_nettype wire

// ===== rtl/core/jgr_mem.sv =====
// ----------------------------------------------------------------------------
// jgr_mem
// Grid buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module jgr_mem #(
	parameter int DEPTH = 4096,
	parameter int W     = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic signed [W-1:0]      wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic signed [W-1:0]           rdata
);

	logic signed [W-1:0] mem [0:DEPTH-1];
	logic signed [W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/jacobi_grid_relaxation.sv =====
// ----------------------------------------------------------------------------
// jacobi_grid_relaxation
// Jacobi relaxation of a square Q16.16 grid with a five-point stencil.
// ----------------------------------------------------------------------------
// Usage:
//  Requests arrive on req_valid/req_stall/req_data, results leave on
//  rsp_valid/rsp_stall/rsp_data. Registers on cfg_* (ready is always high)
//  are to be written only while the block is idle; the user must keep to this.
//  Write requests inside the grid store one cell in both buffers; one is taken
//  per cycle unless requests are stalled, and gives no result. A read passes
//  through the read state, which registers its result; the next request can
//  be taken once the block is back in idle. A start request streams the
//  source buffer through a shift window of 2*GRID_MAX+1 cells, one memory
//  read per cycle: a sweep takes n*GRID_MAX reads and a pipeline drain, and
//  sweeps repeat until the grid converges or the sweep limit is reached, n
//  being the grid side in use.
//  Requests are stalled while a read or a relaxation runs, and while a held
//  result is stalled by the receiver; a stalled result holds its value.
//  Reset returns the registers to their defaults, clears the sweep count and
//  convergence flag and selects grid_a as newest. Grid contents are not
//  cleared: every cell in use must be written before it is read or relaxed.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_grid_relaxation
	import jgr_pkg::*;
#(
	parameter int GRID_MAX   = JGR_GRID_MAX,
	parameter int VALUE_BITS = JGR_VALUE_BITS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire jgr_req_t    req_data,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output jgr_rsp_t         rsp_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [30:0] cfg_data
);

	localparam int GM   = GRID_MAX;
	localparam int VB   = VALUE_BITS;
	localparam int AW   = $clog2(GM * GM);
	localparam int RW   = $clog2(GM);
	localparam int NW   = $clog2(GM + 1);
	localparam int TAPS = 2 * GM + 1;
	localparam int SW   = VB + 2;
	localparam int CW   = (VB + 1 > 32) ? VB + 1 : 32;
	localparam logic [2:0] DRAIN_LAST = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic [6:0]  grid_size_q;
	logic [30:0] precision_q;
	logic [15:0] max_sweeps_q;

	// relaxation state
	logic        cur_q;
	logic [15:0] sweeps_done_q;
	logic        moved_q;
	logic        conv_q;
	logic [15:0] count_q;
	logic [2:0]  drain_q;
	logic        read_inside_q;

	// sweep read counters
	logic [AW-1:0] k_q;
	logic [RW-1:0] rd_row_q;
	logic [RW-1:0] rd_col_q;

	// output register
	logic     rsp_valid_q;
	jgr_rsp_t rsp_q;

	// pipeline
	logic                 rv_s1;
	logic [AW-1:0]        k_s1;
	logic [RW-1:0]        row_s1;
	logic [RW-1:0]        col_s1;
	logic                 int_s2;
	logic [AW-1:0]        addr_s2;
	logic                 valid_s3;
	logic [AW-1:0]        addr_s3;
	logic signed [SW-1:0] sum_s3;
	logic signed [VB-1:0] ctr_s3;
	logic                 valid_s4;
	logic [AW-1:0]        addr_s4;
	logic signed [VB-1:0] newv_s4;
	logic signed [CW-1:0] diff_s4;

	// combinational
	logic [NW-1:0]        n_c;
	logic                 accept_c;
	logic                 inside_c;
	logic [AW-1:0]        item_addr_c;
	logic [AW-1:0]        raddr_c;
	logic signed [VB-1:0] wval_c;
	logic signed [VB-1:0] rdata_a;
	logic signed [VB-1:0] rdata_b;
	logic signed [VB-1:0] rsel_c;
	logic signed [VB-1:0] newv_c;
	logic signed [CW-1:0] prec_c;
	logic                 exceed_c;
	logic                 we_a_c;
	logic                 we_b_c;
	logic [AW-1:0]        waddr_c;
	logic signed [VB-1:0] wdata_c;
	logic                 item_wr_c;
	logic                 sweep_end_c;
	logic [15:0]          limit_c;
	logic [15:0]          cnt_next_c;
	logic signed [VB-1:0] tap [0:TAPS-1];

	// grid side in use, clamped to 3..GRID_MAX
	always_comb begin
		if (int'(grid_size_q) < 3) begin
			n_c = NW'(3);
		end else if (int'(grid_size_q) > GM) begin
			n_c = NW'(GM);
		end else begin
			n_c = NW'(grid_size_q);
		end
	end

	assign req_stall   = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept_c    = req_valid && !req_stall;
	assign inside_c    = (int'(req_data.row) < int'(n_c)) && (int'(req_data.col) < int'(n_c));
	assign item_addr_c = AW'(int'(req_data.row) * GM + int'(req_data.col));
	assign wval_c      = VB'(req_data.cell_value);
	assign item_wr_c   = accept_c && (req_data.mode == MODE_WRITE) && inside_c;
	assign raddr_c     = (state_q == ST_SWEEP) ? k_q : item_addr_c;
	assign rsel_c      = cur_q ? rdata_b : rdata_a;
	assign sweep_end_c = (int'(rd_col_q) == GM - 1) && (int'(rd_row_q) == int'(n_c) - 1);
	assign limit_c     = (max_sweeps_q == 16'd0) ? 16'd1 : max_sweeps_q;
	assign cnt_next_c  = count_q + 16'd1;

	// buffer writes: loader writes both, a sweep writes the older one
	assign we_a_c  = item_wr_c || (valid_s4 && cur_q);
	assign we_b_c  = item_wr_c || (valid_s4 && !cur_q);
	assign waddr_c = item_wr_c ? item_addr_c : addr_s4;
	assign wdata_c = item_wr_c ? wval_c : newv_s4;

	jgr_mem #(.DEPTH(GM * GM), .W(VB)) u_grid_a (
		.clk   (clk),
		.we    (we_a_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.raddr (raddr_c),
		.rdata (rdata_a)
	);

	jgr_mem #(.DEPTH(GM * GM), .W(VB)) u_grid_b (
		.clk   (clk),
		.we    (we_b_c),
		.waddr (waddr_c),
		.wdata (wdata_c),
		.raddr (raddr_c),
		.rdata (rdata_b)
	);

	// stencil window: tap[0] is the cell below the centre, tap[GM] the centre
	for (genvar j = 0; j < TAPS; j++) begin : g_win
		if (j == 0) begin : g_head
			jgr_cell #(.W(VB)) u_cell (
				.clk   (clk),
				.shift (rv_s1),
				.d     (rsel_c),
				.q     (tap[j])
			);
		end else begin : g_body
			jgr_cell #(.W(VB)) u_cell (
				.clk   (clk),
				.shift (rv_s1),
				.d     (tap[j-1]),
				.q     (tap[j])
			);
		end
	end

	// stage 1/2: track the streamed cell and flag interior centres, then pass the flag along the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1    <= 1'b0;
			int_s2   <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			rv_s1    <= (state_q == ST_SWEEP);
			int_s2   <= rv_s1 && (int'(row_s1) >= 2) && (int'(col_s1) >= 1)
				&& (int'(col_s1) + 2 <= int'(n_c));
			valid_s3 <= int_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stencil datapath
	always_ff @(posedge clk) begin
		k_s1    <= k_q;
		row_s1  <= rd_row_q;
		col_s1  <= rd_col_q;
		addr_s2 <= AW'(int'(k_s1) - GM);
		addr_s3 <= addr_s2;
		sum_s3  <= SW'(tap[GM-1]) + SW'(tap[GM+1]) + SW'(tap[2*GM]) + SW'(tap[0]);
		ctr_s3  <= tap[GM];
		addr_s4 <= addr_s3;
		newv_s4 <= newv_c;
		diff_s4 <= CW'(newv_c) - CW'(ctr_s3);
	end

	// floor of the quarter sum, and change test against precision
	always_comb begin
		newv_c   = VB'(sum_s3 >>> 2);
		prec_c   = CW'($signed({1'b0, precision_q}));
		exceed_c = (diff_s4 > prec_c) || (diff_s4 < -prec_c);
	end

	// configuration port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q  <= RST_GRID_SIZE;
			precision_q  <= RST_PRECISION;
			max_sweeps_q <= RST_MAX_SWEEPS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GRID_SIZE:  grid_size_q  <= cfg_data[6:0];
				CFG_PRECISION:  precision_q  <= cfg_data;
				CFG_MAX_SWEEPS: max_sweeps_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// control sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cur_q         <= 1'b0;
			sweeps_done_q <= 16'd0;
			moved_q       <= 1'b0;
			conv_q        <= 1'b0;
			count_q       <= 16'd0;
			drain_q       <= 3'd0;
			read_inside_q <= 1'b0;
			k_q           <= '0;
			rd_row_q      <= '0;
			rd_col_q      <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			// result taken; the read and done states load a new one themselves
			if (rsp_valid_q && !rsp_stall && state_q != ST_READ && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			if (valid_s4 && exceed_c) begin
				moved_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						if (req_data.mode == MODE_START) begin
							count_q  <= 16'd0;
							moved_q  <= 1'b0;
							k_q      <= '0;
							rd_row_q <= '0;
							rd_col_q <= '0;
							state_q  <= ST_SWEEP;
						end else if (req_data.mode == MODE_READ) begin
							read_inside_q <= inside_c;
							state_q       <= ST_READ;
						end
					end
				end
				ST_READ: begin
					rsp_valid_q         <= 1'b1;
					rsp_q.read_value    <= read_inside_q ? 32'(rsel_c) : 32'sd0;
					rsp_q.sweep_count   <= sweeps_done_q;
					rsp_q.converged     <= conv_q;
					state_q             <= ST_IDLE;
				end
				ST_SWEEP: begin
					k_q <= k_q + AW'(1);
					if (int'(rd_col_q) == GM - 1) begin
						rd_col_q <= '0;
						rd_row_q <= rd_row_q + RW'(1);
					end else begin
						rd_col_q <= rd_col_q + RW'(1);
					end
					if (sweep_end_c) begin
						drain_q <= 3'd0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 3'd1;
					if (drain_q == DRAIN_LAST) begin
						cur_q   <= !cur_q;
						count_q <= cnt_next_c;
						if (!moved_q) begin
							conv_q        <= 1'b1;
							sweeps_done_q <= cnt_next_c;
							state_q       <= ST_DONE;
						end else if (cnt_next_c >= limit_c) begin
							conv_q        <= 1'b0;
							sweeps_done_q <= cnt_next_c;
							state_q       <= ST_DONE;
						end else begin
							moved_q  <= 1'b0;
							k_q      <= '0;
							rd_row_q <= '0;
							rd_col_q <= '0;
							state_q  <= ST_SWEEP;
						end
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.read_value  <= 32'sd0;
						rsp_q.sweep_count <= sweeps_done_q;
						rsp_q.converged   <= conv_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/jgr_checker.sv =====
// ----------------------------------------------------------------------------
// jgr_checker
// Port-level checks on the Jacobi grid relaxation block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "jacobi_grid_relaxation_macros.svh"

module jgr_checker
	import jgr_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     req_valid,
	input wire logic     req_stall,
	input wire jgr_req_t req_data,
	input wire logic     rsp_valid,
	input wire logic     rsp_stall,
	input wire jgr_rsp_t rsp_data
);

	// a stalled result stays offered and unchanged
	`JGR_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

	// no new request is taken while a result is held back
	`JGR_ASSERT_NOW(a_req_blocked, rsp_valid && rsp_stall, req_stall)

	// a cell write never yields a result
	`JGR_ASSERT_NEXT(a_write_silent,
		req_valid && !req_stall && req_data.mode == MODE_WRITE && !rsp_valid, !rsp_valid)

	// convergence is only reported after at least one sweep
	`JGR_ASSERT_NOW(a_conv_count, rsp_valid && rsp_data.converged,
		rsp_data.sweep_count != 16'd0)

endmodule

bind jacobi_grid_relaxation jgr_checker u_jgr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_data  (req_data),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_data  (rsp_data)
);

`default_nettype wire

// ===== sim/jacobi_grid_relaxation_test.sv =====
// ----------------------------------------------------------------------------
// Jacobi grid relaxation testbench
// Drives cell write, start, read and mode 3 requests under several register
// settings, idling and stall patterns. Each result is checked against a local
// Q16.16 relaxation predictor that keeps its own copy of both grid buffers.
// ----------------------------------------------------------------------------
`default_nettype none

module jacobi_grid_relaxation_test;
	import jgr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	jgr_req_t    req_data = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	jgr_rsp_t    rsp_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_GRID_SIZE;
	logic [30:0] cfg_data = '0;

	jacobi_grid_relaxation dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic signed [31:0] cell_store [2][JGR_GRID_MAX*JGR_GRID_MAX];
	bit                 newest;
	logic [15:0]        last_sweeps;
	bit                 last_conv;
	logic [6:0]         side_reg;
	logic [30:0]        tol_reg;
	logic [15:0]        sweep_limit_reg;

	jgr_rsp_t pending_results [$];
	int       errors = 0;
	int       idle_pct = 0;
	int       stall_pct = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#400000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int grid_side();
		if (side_reg < 3) return 3;
		if (side_reg > JGR_GRID_MAX) return JGR_GRID_MAX;
		return side_reg;
	endfunction

	// one sweep from the newest buffer into the other; true if a cell moved
	function automatic bit sweep_grid(int n);
		longint s, v, d;
		int     i;
		bit     moved;
		moved = 1'b0;
		for (int r = 1; r + 1 < n; r++) begin
			for (int c = 1; c + 1 < n; c++) begin
				i = r * JGR_GRID_MAX + c;
				s = longint'(cell_store[newest][i-1]) + longint'(cell_store[newest][i+1])
					+ longint'(cell_store[newest][i-JGR_GRID_MAX])
					+ longint'(cell_store[newest][i+JGR_GRID_MAX]);
				v = s >>> 2;
				d = v - longint'(cell_store[newest][i]);
				if (d < 0) d = -d;
				cell_store[!newest][i] = v[31:0];
				if (d > longint'(tol_reg)) moved = 1'b1;
			end
		end
		newest = !newest;
		return moved;
	endfunction

	// model one accepted request
	task automatic predict_request(input jgr_req_t q);
		int       n, lim, cnt;
		bit       in_grid;
		jgr_rsp_t res;
		n = grid_side();
		in_grid = (q.row < n) && (q.col < n);
		res = '0;
		case (q.mode)
			MODE_WRITE: begin
				if (in_grid) begin
					cell_store[0][q.row*JGR_GRID_MAX+q.col] = q.cell_value;
					cell_store[1][q.row*JGR_GRID_MAX+q.col] = q.cell_value;
				end
			end
			MODE_START: begin
				lim = (sweep_limit_reg == 0) ? 1 : sweep_limit_reg;
				cnt = 0;
				forever begin
					cnt++;
					if (!sweep_grid(n)) begin
						last_conv = 1'b1;
						break;
					end
					if (cnt >= lim) begin
						last_conv = 1'b0;
						break;
					end
				end
				last_sweeps = cnt[15:0];
			end
			MODE_READ: begin
				if (in_grid) res.read_value = cell_store[newest][q.row*JGR_GRID_MAX+q.col];
			end
			default: ;
		endcase
		if (q.mode == MODE_START || q.mode == MODE_READ) begin
			res.sweep_count = last_sweeps;
			res.converged = last_conv;
			pending_results.push_back(res);
		end
	endtask

	// send one request, with random idle cycles ahead of it
	task automatic send_request(input logic [1:0] m, input int r, input int c,
		input logic [31:0] v);
		jgr_req_t q;
		q.mode = m;
		q.row = r[5:0];
		q.col = c[5:0];
		q.cell_value = v;
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= q;
		do @(posedge clk); while (req_stall);
		predict_request(q);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		// writes give no result and may still be in flight
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [30:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_GRID_SIZE:  side_reg = val[6:0];
			CFG_PRECISION:  tol_reg = val;
			CFG_MAX_SWEEPS: sweep_limit_reg = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_cell();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h000F_FFFF);
			2: return -$urandom_range(32'h000F_FFFF);
			default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
		endcase
	endfunction

	// every cell of the grid in use gets a value
	task automatic fill_grid();
		int n;
		n = grid_side();
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				send_request(MODE_WRITE, r, c, random_cell());
	endtask

	// result checking
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, rsp_data);
				errors++;
			end else begin
				if (rsp_data.read_value !== pending_results[0].read_value)
					$display("%0t: read_value expected %h actual %h", $time,
						pending_results[0].read_value, rsp_data.read_value);
				if (rsp_data.sweep_count !== pending_results[0].sweep_count)
					$display("%0t: sweep_count expected %0d actual %0d", $time,
						pending_results[0].sweep_count, rsp_data.sweep_count);
				if (rsp_data.converged !== pending_results[0].converged)
					$display("%0t: converged expected %b actual %b", $time,
						pending_results[0].converged, rsp_data.converged);
				if (rsp_data !== pending_results[0]) errors++;
				void'(pending_results.pop_front());
			end
		end
	end

	// receiver stall pattern
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// smallest grid, extreme values, mode 3 and cells outside the grid
	task automatic test_small_grid_extremes();
		write_register(CFG_GRID_SIZE, 31'd0);
		write_register(CFG_PRECISION, 31'd0);
		send_request(MODE_WRITE, 0, 0, 32'h7FFF_FFFF);
		send_request(MODE_WRITE, 0, 1, 32'h7FFF_FFFF);
		send_request(MODE_WRITE, 0, 2, 32'h8000_0000);
		send_request(MODE_WRITE, 1, 0, 32'h7FFF_FFFF);
		send_request(MODE_WRITE, 1, 1, 32'hFFFF_FFFF);
		send_request(MODE_WRITE, 1, 2, 32'h7FFF_FFFF);
		send_request(MODE_WRITE, 2, 0, 32'h0000_0000);
		send_request(MODE_WRITE, 2, 1, 32'h7FFF_FFFF);
		send_request(MODE_WRITE, 2, 2, 32'h8000_0000);
		send_request(MODE_READ, 1, 1, 32'h0);
		send_request(MODE_START, 63, 63, 32'hFFFF_FFFF);
		send_request(MODE_READ, 1, 1, 32'h0);
		send_request(MODE_WRITE, 63, 0, 32'h1234_5678);
		send_request(MODE_READ, 0, 63, 32'h0);
		send_request(2'd3, 1, 1, 32'hFFFF_FFFF);
		send_request(MODE_READ, 2, 2, 32'h0);
		// a zero sweep limit acts as one; converging on that sweep counts
		write_register(CFG_MAX_SWEEPS, 31'd0);
		send_request(MODE_START, 0, 0, 32'h0);
		send_request(MODE_WRITE, 1, 1, 32'h8000_0000);
		send_request(MODE_START, 0, 0, 32'h0);
		send_request(MODE_READ, 1, 1, 32'h0);
		write_register(CFG_PRECISION, 31'h7FFF_FFFF);
		write_register(CFG_MAX_SWEEPS, 31'd65535);
		send_request(MODE_WRITE, 1, 1, 32'h8000_0000);
		send_request(MODE_START, 0, 0, 32'h0);
		send_request(MODE_READ, 1, 1, 32'h0);
	endtask

	// a size above the largest grid acts as the largest
	task automatic test_full_grid();
		write_register(CFG_GRID_SIZE, 31'd127);
		write_register(CFG_MAX_SWEEPS, 31'd1);
		write_register(CFG_PRECISION, 31'd655);
		send_request(MODE_WRITE, 63, 63, random_cell());
		send_request(MODE_WRITE, 32, 31, random_cell());
		send_request(MODE_WRITE, 1, 62, random_cell());
		send_request(MODE_READ, 63, 63, 32'h0);
		send_request(MODE_READ, 32, 31, 32'h0);
		send_request(MODE_READ, 1, 62, 32'h0);
	endtask

	task automatic test_random_traffic(input int rounds);
		int n, sel, r, c;
		for (int k = 0; k < rounds; k++) begin
			write_register(CFG_GRID_SIZE, 31'($urandom_range(3) == 0 ? $urandom_range(2) :
				$urandom_range(3, 7)));
			case ($urandom_range(3))
				0: write_register(CFG_PRECISION, 31'd0);
				1: write_register(CFG_PRECISION, 31'($urandom));
				default: write_register(CFG_PRECISION, 31'($urandom_range(4000)));
			endcase
			write_register(CFG_MAX_SWEEPS, 31'($urandom_range(1, 6)));
			n = grid_side();
			fill_grid();
			for (int j = 0; j < 70; j++) begin
				sel = $urandom_range(99);
				r = $urandom_range(n - 1);
				c = $urandom_range(n - 1);
				if (sel < 40) send_request(MODE_WRITE, r, c, random_cell());
				else if (sel < 78) send_request(MODE_READ, r, c, $urandom);
				else if (sel < 86) send_request(MODE_START, $urandom_range(63),
					$urandom_range(63), $urandom);
				else if (sel < 91) send_request(MODE_WRITE, $urandom_range(n, 63),
					$urandom_range(63), $urandom);
				else if (sel < 96) send_request(MODE_READ, $urandom_range(63),
					$urandom_range(n, 63), $urandom);
				else send_request(2'd3, $urandom_range(63), $urandom_range(63), $urandom);
				if (j == 35) wait_drained();
			end
		end
	endtask

	initial begin
		side_reg = RST_GRID_SIZE;
		tol_reg = RST_PRECISION;
		sweep_limit_reg = RST_MAX_SWEEPS;
		newest = 1'b0;
		last_sweeps = '0;
		last_conv = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_grid_extremes();
		test_full_grid();
		idle_pct = 0;  stall_pct = 0;  test_random_traffic(5);
		idle_pct = 83; stall_pct = 0;  test_random_traffic(5);
		idle_pct = 0;  stall_pct = 83; test_random_traffic(5);
		idle_pct = 18; stall_pct = 18; test_random_traffic(5);
		idle_pct = 0;  stall_pct = 0;

		wait_drained();
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

`default_nettype wire
